// ===== hdl/rar_pkg.sv =====
package rar_pkg;

  // Operand and derived datapath widths
  localparam int OPERAND_WIDTH = 16;
  localparam int CMD_W         = 3;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int NUM_W         = 2 * OPERAND_WIDTH + 1;
  localparam int DEN_W         = 2 * OPERAND_WIDTH;
  localparam int MAG_W         = 2 * OPERAND_WIDTH;
  localparam int CNT_W         = $clog2(MAG_W + 1);

  // Operation codes; unused codes act as reduce
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_RED = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_LOAD,
    ST_CHK,
    ST_REM_WT,
    ST_QN_GO,
    ST_QN_WT,
    ST_QD_GO,
    ST_QD_WT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]                cmd;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } rar_in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic signed [DEN_W-1:0] res_den;
    logic                    err_zero_zero;
  } rar_out_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_op_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Magnitude of a signed raw value
  function automatic logic [MAG_W-1:0] mag(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-1:0] t;
    t = v[NUM_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/rar_mac.sv =====
module rar_mac (
  input  logic                                     clk_i,
  input  rar_pkg::mac_op_t                         op_i,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] a_i,
  input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] b_i,
  output logic signed [rar_pkg::NUM_W-1:0]         acc_o
);
  import rar_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  prod_x;
  logic signed [NUM_W-1:0]  acc_d, acc_q;

  // Form the product and widen it
  assign prod   = a_i * b_i;
  assign prod_x = {prod[PROD_W-1], prod};

  // Load, add or subtract the product
  always_comb begin
    if (op_i.clr) begin
      acc_d = prod_x;
    end else if (op_i.sub) begin
      acc_d = acc_q - prod_x;
    end else begin
      acc_d = acc_q + prod_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/rar_div.sv =====
module rar_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rar_pkg::MAG_W-1:0]   dividend_i,
  input  logic [rar_pkg::MAG_W-1:0]   divisor_i,
  output rar_pkg::div_stat_t          stat_o,
  output logic [rar_pkg::MAG_W-1:0]   quo_o,
  output logic [rar_pkg::MAG_W-1:0]   rem_o
);
  import rar_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MAG_W-1:0] quo_q, rem_q, dvs_q;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   trial;

  // One restoring step: shift in the next dividend bit and try the divisor
  assign shifted = {rem_q, quo_q[MAG_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(MAG_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!trial[MAG_W]) begin
        rem_q <= trial[MAG_W-1:0];
        quo_q <= {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[MAG_W-1:0];
        quo_q <= {quo_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still counting");

  a_done_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(1)) && !start_i |=> done_q)
    else $error("divider missed done after last step");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

endmodule

// ===== hdl/rational_arith_reduce.sv =====
// Channel   | Ports                        | Handshake
// ----------+------------------------------+------------------------------------------
// request   | req_i (rar_in_t)             | taken at a clock edge with start high, busy low
// result    | res_o (rar_out_t)            | valid_o high for one cycle, taken at its end
//
// The time from acceptance to valid_o grows with k, the number of Euclid
// steps (at most about 47 at these widths); zero-over-zero skips the divider.
// Each Euclid step and each of the two final divisions runs the shared restoring
// divider for one bit per cycle over 32 bits.
// busy is high from the accepting edge until the cycle after valid_o.
// Reset clears the sequencer and the divider counter; no clearing pass is needed.
// The receiver cannot stall: a result is shown once and then dropped.
module rational_arith_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rar_pkg::rar_in_t  req_i,
  output logic              valid_o,
  output rar_pkg::rar_out_t res_o
);
  import rar_pkg::*;

  localparam logic signed [OPERAND_WIDTH-1:0] OP_ONE = {{(OPERAND_WIDTH-1){1'b0}}, 1'b1};

  state_e state_q, state_d;

  rar_in_t                  req_q;
  logic signed [NUM_W-1:0]  n_q, x_q, y_q, rn_q;
  logic signed [DEN_W-1:0]  d_q, rd_q;
  logic                     err_q;

  mac_op_t                         mac_op;
  logic signed [OPERAND_WIDTH-1:0] mac_a, mac_b;
  logic signed [NUM_W-1:0]         acc;

  logic             div_start;
  logic [MAG_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
  div_stat_t        div_st;

  logic                    accept;
  logic signed [NUM_W-1:0] d_ext;
  logic [NUM_W-1:0]        rem_ext, quo_ext;

  assign accept  = start && !busy;
  assign d_ext   = {d_q[DEN_W-1], d_q};
  assign rem_ext = {1'b0, div_rem};
  assign quo_ext = {1'b0, div_quo};

  rar_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  rar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_st),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MUL3;
      ST_MUL3:   state_d = ST_LOAD;
      ST_LOAD: begin
        if (n_q == '0 && acc == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (x_q == '0) begin
          state_d = ST_QN_GO;
        end else begin
          state_d = ST_REM_WT;
        end
      end
      ST_REM_WT: if (div_st.done) state_d = ST_CHK;
      ST_QN_GO:  state_d = ST_QN_WT;
      ST_QN_WT:  if (div_st.done) state_d = ST_QD_GO;
      ST_QD_GO:  state_d = ST_QD_WT;
      ST_QD_WT:  if (div_st.done) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Unit controls and operand selection
  always_comb begin
    mac_op       = '0;
    mac_a        = req_q.a_num;
    mac_b        = OP_ONE;
    div_start    = 1'b0;
    div_dividend = mag(y_q);
    div_divisor  = mag(x_q);
    case (state_q)
      ST_MUL1: begin
        mac_op.en  = 1'b1;
        mac_op.clr = 1'b1;
        case (req_q.cmd)
          CMD_ADD, CMD_SUB, CMD_DIV: mac_b = req_q.b_den;
          CMD_MUL:                   mac_b = req_q.b_num;
          default:                   mac_b = OP_ONE;
        endcase
      end
      ST_MUL2: begin
        mac_a = req_q.b_num;
        mac_b = req_q.a_den;
        case (req_q.cmd)
          CMD_ADD: mac_op.en = 1'b1;
          CMD_SUB: begin
            mac_op.en  = 1'b1;
            mac_op.sub = 1'b1;
          end
          default: mac_op.en = 1'b0;
        endcase
      end
      ST_MUL3: begin
        mac_op.en  = 1'b1;
        mac_op.clr = 1'b1;
        case (req_q.cmd)
          CMD_ADD, CMD_SUB, CMD_MUL: begin
            mac_a = req_q.a_den;
            mac_b = req_q.b_den;
          end
          CMD_DIV: begin
            mac_a = req_q.b_num;
            mac_b = req_q.a_den;
          end
          default: begin
            mac_a = req_q.a_den;
            mac_b = OP_ONE;
          end
        endcase
      end
      ST_CHK: div_start = (x_q != '0);
      ST_QN_GO: begin
        div_start    = 1'b1;
        div_dividend = mag(n_q);
        div_divisor  = mag(y_q);
      end
      ST_QD_GO: begin
        div_start    = 1'b1;
        div_dividend = mag(d_ext);
        div_divisor  = mag(y_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers: hold the item, run Euclid, keep the quotients
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    case (state_q)
      ST_MUL3: n_q <= acc;
      ST_LOAD: begin
        d_q <= acc[DEN_W-1:0];
        x_q <= n_q;
        y_q <= acc;
        if (n_q == '0 && acc == '0) begin
          err_q <= 1'b1;
          rn_q  <= '0;
          rd_q  <= '0;
        end else begin
          err_q <= 1'b0;
        end
      end
      ST_REM_WT: begin
        if (div_st.done) begin
          x_q <= y_q[NUM_W-1] ? -$signed(rem_ext) : $signed(rem_ext);
          y_q <= x_q;
        end
      end
      ST_QN_WT: begin
        if (div_st.done) begin
          rn_q <= (n_q[NUM_W-1] ^ y_q[NUM_W-1]) ? -$signed(quo_ext) : $signed(quo_ext);
        end
      end
      ST_QD_WT: begin
        if (div_st.done) begin
          rd_q <= (d_q[DEN_W-1] ^ y_q[NUM_W-1]) ? -$signed(div_quo) : $signed(div_quo);
        end
      end
      default: begin
      end
    endcase
  end

  // Result ports
  assign busy                = (state_q != ST_IDLE);
  assign valid_o             = (state_q == ST_OUT);
  assign res_o.res_num       = rn_q;
  assign res_o.res_den       = rd_q;
  assign res_o.err_zero_zero = err_q;

  a_start_divider_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while running");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !valid_o)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy)
    else $error("result strobe longer than one cycle");

  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.err_zero_zero |-> res_o.res_num == '0 && res_o.res_den == '0)
    else $error("zero-over-zero result not cleared");

  a_no_err_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.err_zero_zero |-> res_o.res_num != '0 || res_o.res_den != '0)
    else $error("reduced result is zero over zero");

endmodule
